[rtl/mdbr_pkg.sv]
// ----------------------------------------------------------------------------
// mdbr_pkg
// Shared types and codes for the MIPS32 decode and branch resolve stage:
// opcode and function codes, ALU operation codes and the beat layouts.
// ----------------------------------------------------------------------------
package mdbr_pkg;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL  = 6'h00;
  localparam logic [5:0] OP_REGIMM   = 6'h01;
  localparam logic [5:0] OP_J        = 6'h02;
  localparam logic [5:0] OP_JAL      = 6'h03;
  localparam logic [5:0] OP_BEQ      = 6'h04;
  localparam logic [5:0] OP_BNE      = 6'h05;
  localparam logic [5:0] OP_BLEZ     = 6'h06;
  localparam logic [5:0] OP_BGTZ     = 6'h07;
  localparam logic [5:0] OP_ADDI     = 6'h08;
  localparam logic [5:0] OP_ADDIU    = 6'h09;
  localparam logic [5:0] OP_SLTI     = 6'h0A;
  localparam logic [5:0] OP_SLTIU    = 6'h0B;
  localparam logic [5:0] OP_ANDI     = 6'h0C;
  localparam logic [5:0] OP_ORI      = 6'h0D;
  localparam logic [5:0] OP_XORI     = 6'h0E;
  localparam logic [5:0] OP_LUI      = 6'h0F;
  localparam logic [5:0] OP_SPECIAL3 = 6'h1F;
  localparam logic [5:0] OP_LB       = 6'h20;
  localparam logic [5:0] OP_LH       = 6'h21;
  localparam logic [5:0] OP_LW       = 6'h23;
  localparam logic [5:0] OP_LBU      = 6'h24;
  localparam logic [5:0] OP_LHU      = 6'h25;
  localparam logic [5:0] OP_SB       = 6'h28;
  localparam logic [5:0] OP_SH       = 6'h29;
  localparam logic [5:0] OP_SW       = 6'h2B;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MOVZ = 6'h0A;
  localparam logic [5:0] FN_MOVN = 6'h0B;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  // SPECIAL3 byte shuffle
  localparam logic [5:0] FN_BSHFL = 6'h20;
  localparam logic [4:0] SH_SEB   = 5'h10;
  localparam logic [4:0] SH_SEH   = 5'h18;

  // fixed indices and amounts
  localparam logic [4:0] LINK_REG  = 5'd31;
  localparam logic [4:0] LUI_SHIFT = 5'd16;

  // input beat width, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned OUT_TDATA_W = 128;

  typedef enum logic [3:0] {
    ALU_ADD  = 4'd0,
    ALU_ADDU = 4'd1,
    ALU_AND  = 4'd2,
    ALU_MOVZ = 4'd3,
    ALU_MOVN = 4'd4,
    ALU_NOR  = 4'd5,
    ALU_OR   = 4'd6,
    ALU_SLL  = 4'd7,
    ALU_SRL  = 4'd8,
    ALU_SLT  = 4'd9,
    ALU_SLTU = 4'd10,
    ALU_SUB  = 4'd11,
    ALU_SUBU = 4'd12,
    ALU_XOR  = 4'd13,
    ALU_SEB  = 4'd14,
    ALU_SEH  = 4'd15
  } alu_op_e;

  // control bits, msb first
  typedef struct packed {
    logic taken;
    logic jump;
    logic memwrite;
    logic memread;
    logic regwrite;
    logic memtoreg;
    logic alusrc;
    logic regdst;
  } ctrl_t;

  // input instruction, first field in the top bits
  typedef struct packed {
    logic        [31:0] rt_value;
    logic        [31:0] rs_value;
    logic        [31:0] pc_next;
    logic        [25:0] jump_target;
    logic signed [15:0] immediate;
    logic        [5:0]  func;
    logic        [4:0]  shamt;
    logic        [4:0]  rd_index;
    logic        [4:0]  rt_index;
    logic        [4:0]  rs_index;
    logic        [5:0]  opcode;
  } instr_t;

  // decoded beat, first field in the top bits
  typedef struct packed {
    logic    [4:0]  shift_amount;
    logic    [4:0]  rd_out;
    logic    [4:0]  rt_out;
    logic    [4:0]  rs_out;
    logic    [31:0] rt_operand;
    logic    [31:0] rs_operand;
    logic    [31:0] next_pc;
    ctrl_t          control_bits;
    alu_op_e        alu_op;
  } dec_beat_t;

  typedef struct packed {
    logic      illegal;
    dec_beat_t beat;
  } dec_result_t;

endpackage

[rtl/mdbr_decode.sv]
// ----------------------------------------------------------------------------
// mdbr_decode
// Combinational decode of one instruction: ALU operation, control bits,
// index overrides, branch condition and next PC selection.
// ----------------------------------------------------------------------------
module mdbr_decode
  import mdbr_pkg::*;
(
  input  instr_t      instr_i,
  output dec_result_t result_o
);

  alu_op_e     op;
  ctrl_t       cb;
  logic        ok;
  logic        is_jr;
  logic        is_jabs;
  logic        taken;
  logic        rs_neg;
  logic        rs_zero;
  logic [4:0]  rs_idx;
  logic [4:0]  rt_idx;
  logic [4:0]  rd_idx;
  logic [4:0]  sh;
  logic [31:0] br_offset;
  logic [31:0] npc;

  assign rs_neg    = instr_i.rs_value[31];
  assign rs_zero   = (instr_i.rs_value == 32'd0);
  assign br_offset = {{14{instr_i.immediate[15]}}, instr_i.immediate, 2'b00};

  // opcode and function decode
  always_comb begin
    op      = ALU_ADD;
    cb      = '0;
    ok      = 1'b1;
    is_jr   = 1'b0;
    is_jabs = 1'b0;
    taken   = 1'b0;
    rs_idx  = instr_i.rs_index;
    rt_idx  = instr_i.rt_index;
    rd_idx  = instr_i.rd_index;
    sh      = instr_i.shamt;
    unique case (instr_i.opcode) inside
      OP_SPECIAL: begin
        cb.regdst   = 1'b1;
        cb.regwrite = 1'b1;
        unique case (instr_i.func)
          FN_ADD:  op = ALU_ADD;
          FN_ADDU: op = ALU_ADDU;
          FN_AND:  op = ALU_AND;
          FN_JR: begin
            op          = ALU_ADD;
            is_jr       = 1'b1;
            cb.regwrite = 1'b0;
            cb.jump     = 1'b1;
          end
          FN_MOVZ: op = ALU_MOVZ;
          FN_MOVN: op = ALU_MOVN;
          FN_NOR:  op = ALU_NOR;
          FN_OR:   op = ALU_OR;
          FN_SLL:  op = ALU_SLL;
          FN_SRL:  op = ALU_SRL;
          FN_SLT:  op = ALU_SLT;
          FN_SLTU: op = ALU_SLTU;
          FN_SUB:  op = ALU_SUB;
          FN_SUBU: op = ALU_SUBU;
          FN_XOR:  op = ALU_XOR;
          default: ok = 1'b0;
        endcase
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        op          = ALU_ADDU;
        cb.alusrc   = 1'b1;
        cb.memtoreg = 1'b1;
        cb.regwrite = 1'b1;
        cb.memread  = 1'b1;
      end
      OP_SB, OP_SH, OP_SW: begin
        op          = ALU_ADDU;
        cb.alusrc   = 1'b1;
        cb.memwrite = 1'b1;
      end
      OP_BEQ: begin
        op    = ALU_SUB;
        taken = (instr_i.rs_value == instr_i.rt_value);
      end
      OP_BNE: begin
        op    = ALU_SUB;
        taken = (instr_i.rs_value != instr_i.rt_value);
      end
      OP_REGIMM: begin
        // only BLTZ is defined here
        if (instr_i.rt_index != 5'd0) begin
          ok = 1'b0;
        end else begin
          op    = ALU_SUB;
          taken = rs_neg;
        end
      end
      OP_BGTZ: begin
        op    = ALU_SUB;
        taken = !rs_neg && !rs_zero;
      end
      OP_BLEZ: begin
        op    = ALU_SUB;
        taken = rs_neg || rs_zero;
      end
      OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_SLTI, OP_SLTIU, OP_XORI, OP_LUI: begin
        cb.alusrc   = 1'b1;
        cb.regwrite = 1'b1;
        unique case (instr_i.opcode)
          OP_ADDI:  op = ALU_ADD;
          OP_ADDIU: op = ALU_ADDU;
          OP_ANDI:  op = ALU_AND;
          OP_ORI:   op = ALU_OR;
          OP_SLTI:  op = ALU_SLT;
          OP_SLTIU: op = ALU_SLTU;
          OP_XORI:  op = ALU_XOR;
          default: begin
            // lui is a shift left by sixteen
            op = ALU_SLL;
            sh = LUI_SHIFT;
          end
        endcase
      end
      OP_J, OP_JAL: begin
        op          = ALU_ADDU;
        cb.regdst   = 1'b1;
        cb.regwrite = 1'b1;
        cb.jump     = 1'b1;
        is_jabs     = 1'b1;
        rs_idx      = 5'd0;
        rt_idx      = 5'd0;
        rd_idx      = (instr_i.opcode == OP_JAL) ? LINK_REG : 5'd0;
      end
      OP_SPECIAL3: begin
        cb.regdst   = 1'b1;
        cb.regwrite = 1'b1;
        if (instr_i.func == FN_BSHFL && instr_i.shamt == SH_SEB) begin
          op = ALU_SEB;
        end else if (instr_i.func == FN_BSHFL && instr_i.shamt == SH_SEH) begin
          op = ALU_SEH;
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase

    // undefined encodings write nothing and never redirect
    if (!ok) begin
      op      = ALU_ADD;
      cb      = '0;
      taken   = 1'b0;
      is_jr   = 1'b0;
      is_jabs = 1'b0;
    end
    cb.taken = taken;
  end

  // next pc selection
  always_comb begin
    if (is_jabs) begin
      npc = {instr_i.pc_next[31:28], instr_i.jump_target, 2'b00};
    end else if (is_jr) begin
      npc = instr_i.rs_value;
    end else begin
      npc = instr_i.pc_next + br_offset;
    end
  end

  // result assembly, j and jal pass the link address as second operand
  always_comb begin
    result_o.illegal           = !ok;
    result_o.beat.alu_op       = op;
    result_o.beat.control_bits = cb;
    result_o.beat.next_pc      = npc;
    result_o.beat.rs_operand   = is_jabs ? 32'd0 : instr_i.rs_value;
    result_o.beat.rt_operand   = is_jabs ? instr_i.pc_next : instr_i.rt_value;
    result_o.beat.rs_out       = rs_idx;
    result_o.beat.rt_out       = rt_idx;
    result_o.beat.rd_out       = rd_idx;
    result_o.beat.shift_amount = sh;
  end

endmodule

[rtl/mips_decode_branch_resolve_core.sv]
// ----------------------------------------------------------------------------
// mips_decode_branch_resolve_core
// MIPS32 decode and branch resolve, one instruction per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each input beat carries one pre-split instruction with PC+4 and both source
// register values; each output beat carries its decoded controls, operands,
// indices and next PC. The core is two register stages: an input register and
// a result register with the decode logic between them. It takes one beat per
// cycle unless the output stalls; a beat goes via the input then the result
// register. A stalled output only holds off the input once both are full.
// Undefined encodings come out with tuser set and all control bits clear.
module mips_decode_branch_resolve_core
  import mdbr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // low to high: opcode, rs_index, rt_index, rd_index, shamt, func, immediate,
  // jump_target, pc_next, rs_value, rt_value, zero padding
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // low to high: alu_op, control_bits, next_pc, rs_operand, rt_operand,
  // rs_out, rt_out, rd_out, shift_amount
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // illegal
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i
);

  logic        in_valid_q;
  instr_t      in_data_q;
  logic        out_valid_q;
  dec_result_t out_data_q;
  dec_result_t dec_result;
  logic        out_advance;
  logic        in_advance;

  // handshake: each stage moves when the next one has room
  assign out_advance     = !out_valid_q || m_axis_tready_i;
  assign in_advance      = !in_valid_q || out_advance;
  assign s_axis_tready_o = in_advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_advance) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_advance && s_axis_tvalid_i) begin
      in_data_q <= instr_t'(s_axis_tdata_i[$bits(instr_t)-1:0]);
    end
  end

  mdbr_decode u_decode (
    .instr_i  (in_data_q),
    .result_o (dec_result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      out_data_q <= dec_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q.beat;
  assign m_axis_tuser_o  = out_data_q.illegal;

endmodule
